// ===== sv/rle_dec_pkg.sv =====
// shared types and constants of the run-length scanline decoder
package rle_dec_pkg;

  localparam int unsigned RowW     = 13;
  localparam int unsigned PlaneW   = 3;
  localparam int unsigned PlaneCfW = 4;
  localparam int unsigned PatW     = 8;
  localparam int unsigned HeightW  = 15;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned ProdW    = 16;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [7:0] OpBits   = 8'h80;
  localparam logic [7:0] OpVrep   = 8'hFF;
  localparam logic [7:0] FillOnes = 8'hFF;
  localparam logic [6:0] RunMask  = 7'h7F;
  localparam logic [PlaneCfW-1:0] MaxPlanes = 4'd8;
  localparam logic [HeightW-1:0]  MaxLines  = 15'h7FFF;

  typedef enum logic [1:0] {
    CFG_ROW_BYTES    = 2'd0,
    CFG_PLANE_COUNT  = 2'd1,
    CFG_PATTERN_LEN  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_FILL = 2'd1,
    KIND_COPY = 2'd2,
    KIND_MARK = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        value;
    logic [RowW-1:0]   count;
    logic [PlaneW-1:0] plane_index;
    logic              row_end;
    logic              scanline_end;
    logic [7:0]        repeat_lines;
    logic              image_end;
  } res_t;

  // results of one accepted input beat
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

// ===== sv/rle_dec_core.sv =====
// opcode parser, row and scanline bookkeeping and configuration registers
module rle_dec_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  rle_dec_pkg::cfg_idx_e               cfg_index_i,
  input  logic [rle_dec_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                                accept_i,
  input  logic [7:0]                          data_byte_i,
  input  logic                                at_end_i,
  output rle_dec_pkg::step_t                  step_o
);
  import rle_dec_pkg::*;

  typedef enum logic [6:0] {
    PH_OPCODE     = 7'b0000001,
    PH_ZERO       = 7'b0000010,
    PH_VREP_MARK  = 7'b0000100,
    PH_VREP_COUNT = 7'b0001000,
    PH_BITS_LEN   = 7'b0010000,
    PH_BITS_DATA  = 7'b0100000,
    PH_PAT_DATA   = 7'b1000000
  } phase_e;

  logic [RowW-1:0]     row_bytes_q;
  logic [PlaneCfW-1:0] plane_count_q;
  logic [PatW-1:0]     pattern_len_q;
  logic [HeightW-1:0]  image_height_q;

  phase_e              phase_q, phase_d;
  logic [7:0]          bytes_left_q, bytes_left_d;
  logic [7:0]          pat_reps_q, pat_reps_d;
  logic [RowW-1:0]     pos_q, pos_d;
  logic [PlaneW-1:0]   plane_q, plane_d;
  logic [HeightW-1:0]  lines_q, lines_d;
  logic [7:0]          line_rep_q, line_rep_d;
  logic                finished_q, finished_d;

  function automatic res_t mk_res(kind_e k, logic [7:0] v, logic [RowW-1:0] c,
                                  logic [PlaneW-1:0] p);
    res_t r;
    r.kind         = k;
    r.value        = v;
    r.count        = c;
    r.plane_index  = p;
    r.row_end      = 1'b0;
    r.scanline_end = 1'b0;
    r.repeat_lines = 8'd1;
    r.image_end    = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [RowW-1:0]     room;
    logic [RowW-1:0]     room2;
    logic [RowW-1:0]     run;
    logic [ProdW-1:0]    copy;
    logic [7:0]          reps_m1;
    logic [7:0]          left_dec;
    logic                lit;
    logic                do_fin;
    logic                force_end;
    logic [PlaneCfW-1:0] planes;
    logic [HeightW-1:0]  height;
    logic [HeightW-1:0]  remaining;
    logic [HeightW-1:0]  rep;
    logic [HeightW:0]    sum;
    logic                scan_end;
    logic                img_end;
    res_t                r0;
    res_t                r1;
    logic [1:0]          num;

    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    pat_reps_d   = pat_reps_q;
    pos_d        = pos_q;
    plane_d      = plane_q;
    lines_d      = lines_q;
    line_rep_d   = line_rep_q;
    finished_d   = finished_q;
    do_fin       = 1'b0;
    force_end    = 1'b0;
    num          = 2'd0;
    r0           = mk_res(KIND_MARK, 8'd0, '0, plane_q);
    r1           = mk_res(KIND_MARK, 8'd0, '0, plane_q);
    room         = (pos_q < row_bytes_q) ? row_bytes_q - pos_q : '0;
    room2        = room;
    run          = '0;
    copy         = '0;
    reps_m1      = (pat_reps_q != 8'd0) ? pat_reps_q - 8'd1 : 8'd0;
    left_dec     = '0;
    lit          = 1'b0;
    scan_end     = 1'b0;
    img_end      = 1'b0;
    rep          = '0;
    sum          = '0;
    planes       = '0;
    height       = '0;
    remaining    = '0;

    if (accept_i && !finished_q) begin
      if (at_end_i) begin
        phase_d      = PH_OPCODE;
        bytes_left_d = '0;
        pat_reps_d   = '0;
        do_fin       = 1'b1;
        force_end    = 1'b1;
      end else begin
        unique case (phase_q)
          PH_OPCODE: begin
            if (data_byte_i == 8'd0) begin
              phase_d = PH_ZERO;
            end else if (data_byte_i == OpBits) begin
              phase_d = PH_BITS_LEN;
            end else begin
              run = {6'd0, data_byte_i[6:0] & RunMask};
              if (run > room) run = room;
              if (run != '0) begin
                r0    = mk_res(KIND_FILL, data_byte_i[7] ? FillOnes : 8'd0, run, plane_q);
                num   = 2'd1;
                pos_d = pos_q + run;
              end
              do_fin = 1'b1;
            end
          end
          PH_ZERO: begin
            if (data_byte_i != 8'd0) begin
              pat_reps_d = data_byte_i;
              if (pattern_len_q == '0) begin
                phase_d = PH_OPCODE;
                do_fin  = 1'b1;
              end else begin
                bytes_left_d = pattern_len_q;
                phase_d      = PH_PAT_DATA;
              end
            end else begin
              phase_d = PH_VREP_MARK;
            end
          end
          PH_VREP_MARK: begin
            if (data_byte_i == OpVrep) begin
              phase_d = PH_VREP_COUNT;
            end else begin
              phase_d = PH_OPCODE;
              do_fin  = 1'b1;
            end
          end
          PH_VREP_COUNT: begin
            line_rep_d = (data_byte_i == 8'd0) ? 8'd1 : data_byte_i;
            phase_d    = PH_OPCODE;
            do_fin     = 1'b1;
          end
          PH_BITS_LEN: begin
            if (data_byte_i == 8'd0) begin
              phase_d = PH_OPCODE;
              do_fin  = 1'b1;
            end else begin
              bytes_left_d = data_byte_i;
              phase_d      = PH_BITS_DATA;
            end
          end
          PH_BITS_DATA, PH_PAT_DATA: begin
            lit = (room != '0);
            if (lit) begin
              r0    = mk_res(KIND_LIT, data_byte_i, RowW'(1), plane_q);
              num   = 2'd1;
              pos_d = pos_q + RowW'(1);
            end
            left_dec     = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;
            bytes_left_d = left_dec;
            if (left_dec == 8'd0) begin
              if (phase_q == PH_PAT_DATA) begin
                room2 = room - {{(RowW-1){1'b0}}, lit};
                // bytes of the copies that follow the first pattern
                copy  = ProdW'({8'd0, reps_m1} * {8'd0, pattern_len_q});
                if (copy > {{(ProdW-RowW){1'b0}}, room2}) copy = {{(ProdW-RowW){1'b0}}, room2};
                if (copy != '0) begin
                  if (lit) begin
                    r1  = mk_res(KIND_COPY, 8'd0, copy[RowW-1:0], plane_q);
                    num = 2'd2;
                  end else begin
                    r0  = mk_res(KIND_COPY, 8'd0, copy[RowW-1:0], plane_q);
                    num = 2'd1;
                  end
                  pos_d = pos_d + copy[RowW-1:0];
                end
              end
              phase_d = PH_OPCODE;
              do_fin  = 1'b1;
            end
          end
          default: begin
            phase_d = PH_OPCODE;
          end
        endcase
      end

      // row end, and with the last plane the scanline end
      if (do_fin && (force_end || pos_d >= row_bytes_q)) begin
        if (num == 2'd0) begin
          num = 2'd1;
        end
        pos_d  = '0;
        planes = (plane_count_q == '0) ? PlaneCfW'(1) :
                 ((plane_count_q > MaxPlanes) ? MaxPlanes : plane_count_q);
        if ({1'b0, plane_q} + PlaneCfW'(1) >= planes) begin
          scan_end  = 1'b1;
          height    = (image_height_q == '0) ? HeightW'(1) : image_height_q;
          remaining = (lines_q < height) ? height - lines_q : HeightW'(1);
          // a replication count taken in this beat already applies
          rep       = {7'd0, line_rep_d};
          if (rep > remaining) rep = remaining;
          sum       = {1'b0, lines_q} + {1'b0, rep};
          lines_d   = sum[HeightW] ? MaxLines : sum[HeightW-1:0];
          if (lines_d >= height) begin
            finished_d = 1'b1;
            img_end    = 1'b1;
          end
          plane_d    = '0;
          line_rep_d = 8'd1;
        end else begin
          plane_d = plane_q + PlaneW'(1);
        end
        if (num == 2'd2) begin
          r1.row_end      = 1'b1;
          r1.scanline_end = scan_end;
          r1.repeat_lines = scan_end ? rep[7:0] : 8'd1;
          r1.image_end    = img_end;
        end else begin
          r0.row_end      = 1'b1;
          r0.scanline_end = scan_end;
          r0.repeat_lines = scan_end ? rep[7:0] : 8'd1;
          r0.image_end    = img_end;
        end
      end
    end

    step_o.num = num;
    step_o.r0  = r0;
    step_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q    <= RowW'(80);
      plane_count_q  <= PlaneCfW'(1);
      pattern_len_q  <= PatW'(2);
      image_height_q <= HeightW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_BYTES:    row_bytes_q    <= cfg_data_i[RowW-1:0];
        CFG_PLANE_COUNT:  plane_count_q  <= cfg_data_i[PlaneCfW-1:0];
        CFG_PATTERN_LEN:  pattern_len_q  <= cfg_data_i[PatW-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_OPCODE;
      bytes_left_q <= '0;
      pat_reps_q   <= '0;
      pos_q        <= '0;
      plane_q      <= '0;
      lines_q      <= '0;
      line_rep_q   <= 8'd1;
      finished_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      pat_reps_q   <= pat_reps_d;
      pos_q        <= pos_d;
      plane_q      <= plane_d;
      lines_q      <= lines_d;
      line_rep_q   <= line_rep_d;
      finished_q   <= finished_d;
    end
  end

endmodule

// ===== sv/rle_dec_fifo.sv =====
// four-entry result queue that takes up to two results a cycle and gives one when popped
module rle_dec_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rle_dec_pkg::step_t push_i,
  input  logic               pop_i,
  output logic               not_empty_o,
  output logic               room2_o,
  output rle_dec_pkg::res_t  head_o
);
  import rle_dec_pkg::*;

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_pop;

  assign do_pop      = pop_i && (cnt_q != '0);
  assign not_empty_o = (cnt_q != '0);
  // two free entries needed for the worst beat
  assign room2_o     = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign head_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + FifoPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoPtrW'(push_i.num);
      rd_q  <= rd_q + FifoPtrW'(do_pop);
      cnt_q <= cnt_q + FifoCntW'(push_i.num) - FifoCntW'(do_pop);
    end
  end

endmodule

// ===== sv/img_rle_scanline_decoder.sv =====
// top level of the run-length scanline decoder
//
//  channel  direction  handshake               payload
//  in       sink       in_valid_i/in_stall_o   data_byte_i, at_end_i
//  out      source     out_valid_o/out_stall_i kind, value, count, plane_index, marks
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one input beat per cycle while in_stall_o is low; its results enter the queue at the accepting edge
// and are offered in order from the queue head, one result per output beat
// a beat with two results gives a literal beat and then a copy beat
// in_stall_o rises when the four-entry result queue has fewer than two free slots
// reset clears parser state, queue and registers to their defaults; no clearing pass
module img_rle_scanline_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        at_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  value_o,
  output logic [12:0] count_o,
  output logic [2:0]  plane_index_o,
  output logic        row_end_o,
  output logic        scanline_end_o,
  output logic [7:0]  repeat_lines_o,
  output logic        image_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  import rle_dec_pkg::*;

  step_t step;
  res_t  head;
  logic  room2;
  logic  accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room2;
  assign accept      = in_valid_i && room2;

  rle_dec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .at_end_i    (at_end_i),
    .step_o      (step)
  );

  rle_dec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .pop_i       (!out_stall_i),
    .not_empty_o (out_valid_o),
    .room2_o     (room2),
    .head_o      (head)
  );

  assign kind_o         = head.kind;
  assign value_o        = head.value;
  assign count_o        = head.count;
  assign plane_index_o  = head.plane_index;
  assign row_end_o      = head.row_end;
  assign scanline_end_o = head.scanline_end;
  assign repeat_lines_o = head.repeat_lines;
  assign image_end_o    = head.image_end;

endmodule

// ===== sv/rle_dec_checker.sv =====
// port-level checks of the decoder and the bind that attaches them
module rle_dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [1:0]  kind_i,
  input logic [7:0]  value_i,
  input logic [12:0] count_i,
  input logic        row_end_i,
  input logic        scanline_end_i,
  input logic [7:0]  repeat_lines_i,
  input logic        image_end_i
);
  import rle_dec_pkg::*;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(kind_i) && $stable(count_i) && $stable(value_i))
    else $error("stalled result changed");

  a_marker_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_MARK |-> row_end_i && count_i == '0 && value_i == '0)
    else $error("marker beat without row end or with data");

  a_scan_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (scanline_end_i || image_end_i) |-> row_end_i && scanline_end_i)
    else $error("scanline or image end without row end");

  a_repeat_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !scanline_end_i |-> repeat_lines_i == 8'd1)
    else $error("copy count outside scanline end");

endmodule

bind img_rle_scanline_decoder rle_dec_checker u_rle_dec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_i         (kind_o),
  .value_i        (value_o),
  .count_i        (count_o),
  .row_end_i      (row_end_o),
  .scanline_end_i (scanline_end_o),
  .repeat_lines_i (repeat_lines_o),
  .image_end_i    (image_end_o)
);
